>>> hdl/ted_pkg.sv
`default_nettype none

package ted_pkg;

	// Verdict codes given on the result stream.
	typedef enum logic [2:0] {
		VERDICT_UNKNOWN  = 3'd0,
		VERDICT_UTF16_BE = 3'd1,
		VERDICT_UTF16_LE = 3'd2,
		VERDICT_UTF8_BOM = 3'd3,
		VERDICT_UTF8     = 3'd4,
		VERDICT_ANSI     = 3'd5
	} verdict_t;

	// Byte-order mark bytes.
	localparam logic [7:0] BOM_FE = 8'hfe;
	localparam logic [7:0] BOM_FF = 8'hff;
	localparam logic [7:0] BOM_EF = 8'hef;
	localparam logic [7:0] BOM_BB = 8'hbb;
	localparam logic [7:0] BOM_BF = 8'hbf;

	// UTF-8 class masks and their matching patterns.
	localparam logic [7:0] MASK_2 = 8'hc0;
	localparam logic [7:0] MASK_3 = 8'he0;
	localparam logic [7:0] MASK_4 = 8'hf0;
	localparam logic [7:0] MASK_5 = 8'hf8;
	localparam logic [7:0] PAT_CONT  = 8'h80;
	localparam logic [7:0] PAT_LEAD2 = 8'hc0;
	localparam logic [7:0] PAT_LEAD3 = 8'he0;
	localparam logic [7:0] PAT_LEAD4 = 8'hf0;

	// Byte count saturation and length of the captured head.
	localparam logic [2:0] COUNT_MAX  = 3'd4;
	localparam logic [2:0] HEAD_DEPTH = 3'd3;

	// One byte handed from the input register to the tracker.
	typedef struct packed {
		logic       step;
		logic [7:0] data_byte;
		logic       last_byte;
	} ted_step_t;

endpackage

`default_nettype wire

>>> hdl/ted_track.sv
`default_nettype none

module ted_track
	import ted_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ted_step_t step_in,
	output verdict_t       verdict
);

	logic [2:0] count_q;
	logic [7:0] head_q [3];
	logic [1:0] pending_q;
	logic       error_q;

	logic [2:0] count_nx;
	logic [7:0] head_nx [3];
	logic [1:0] pending_nx;
	logic       error_nx;
	logic [7:0] b;

	assign b = step_in.data_byte;

	// Next state for the byte in the input register.
	always_comb begin
		count_nx   = (count_q >= COUNT_MAX) ? COUNT_MAX : count_q + 3'd1;
		head_nx    = head_q;
		pending_nx = pending_q;
		error_nx   = error_q;
		if (count_q < HEAD_DEPTH) begin
			head_nx[count_q[1:0]] = b;
		end
		if (pending_q != 2'd0) begin
			if ((b & MASK_2) != PAT_CONT) begin
				error_nx = 1'b1;
			end
			pending_nx = pending_q - 2'd1;
		end else if (b[7] == 1'b0) begin
			pending_nx = 2'd0;
		end else if ((b & MASK_3) == PAT_LEAD2) begin
			pending_nx = 2'd1;
		end else if ((b & MASK_4) == PAT_LEAD3) begin
			pending_nx = 2'd2;
		end else if ((b & MASK_5) == PAT_LEAD4) begin
			pending_nx = 2'd3;
		end else begin
			error_nx = 1'b1;
		end
	end

	// Verdict from the state that includes the final byte.
	always_comb begin
		if (count_nx <= HEAD_DEPTH) begin
			verdict = VERDICT_UNKNOWN;
		end else if (head_nx[0] == BOM_FE && head_nx[1] == BOM_FF) begin
			verdict = VERDICT_UTF16_BE;
		end else if (head_nx[0] == BOM_FF && head_nx[1] == BOM_FE) begin
			verdict = VERDICT_UTF16_LE;
		end else if (head_nx[0] == BOM_EF && head_nx[1] == BOM_BB
			&& head_nx[2] == BOM_BF) begin
			verdict = VERDICT_UTF8_BOM;
		end else if (error_nx || pending_nx != 2'd0) begin
			verdict = VERDICT_ANSI;
		end else begin
			verdict = VERDICT_UTF8;
		end
	end

	// State registers; the final byte of a buffer returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 3'd0;
			head_q    <= '{default: 8'h00};
			pending_q <= 2'd0;
			error_q   <= 1'b0;
		end else if (step_in.step) begin
			if (step_in.last_byte) begin
				count_q   <= 3'd0;
				head_q    <= '{default: 8'h00};
				pending_q <= 2'd0;
				error_q   <= 1'b0;
			end else begin
				count_q   <= count_nx;
				head_q    <= head_nx;
				pending_q <= pending_nx;
				error_q   <= error_nx;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/text_encoding_detector_unit.sv
`default_nettype none
// A final byte reaches m_tdata as a verdict via the input and result registers.
// Throughput: one byte per cycle while no final byte is held; bytes that are not final never wait for the output.
// A final byte waits in the input register only while an earlier verdict is untaken.
// Reset (arst_n low, asynchronous) empties both registers and clears the byte count,
// the captured head bytes, the pending continuation count and the error flag.

module text_encoding_detector_unit
	import ted_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] data_byte
	input  wire logic       s_tlast,   // last_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata    // [2:0] verdict, [7:3] zero
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       advance;
	ted_step_t  step;
	verdict_t   verdict;
	verdict_t   verdict_q;

	// A final byte moves on only when the result register can take its verdict.
	assign out_free = !m_tvalid || m_tready;
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	assign step.step      = advance;
	assign step.data_byte = byte_s1;
	assign step.last_byte = last_s1;

	ted_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_in (step),
		.verdict (verdict)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict;
		end
	end

	assign m_tdata = {5'd0, verdict_q};

endmodule

`default_nettype wire

>>> hdl/ted_checker.sv
`default_nettype none

module ted_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// A stalled verdict holds its beat.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled verdict changed");

	// Only defined verdict codes appear, with zero padding.
	a_out_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] == 5'd0 && m_tdata[2:0] != 3'd6
			&& m_tdata[2:0] != 3'd7)
		else $error("verdict code out of range");

	// Input is taken whenever the output side is free.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

	// A new verdict needs a final byte accepted earlier.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2)
			|| !$past(s_tready))
		else $error("verdict without a final byte");

endmodule

bind text_encoding_detector_unit ted_checker u_ted_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> verif/tb_text_encoding_detector_unit.sv
`default_nettype none

module tb_text_encoding_detector_unit;
	import ted_pkg::*;

	localparam int RANDOM_BYTES = 1900;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 14;
	localparam int CALM_FROM    = 1000;
	localparam int CALM_TO      = 1600;
	localparam int DRAIN_CYCLES = 8;

	// One row of the directed stimulus: a byte, its last flag, and an optional
	// hand-typed verdict that replaces the predicted one.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fixed;
		verdict_t   verdict;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;   // [7:0] data_byte
	logic       s_tlast = 1'b0;    // last_byte
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;           // [2:0] verdict, [7:3] zero

	text_encoding_detector_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Predictor state of the buffer being classified.
	logic [2:0] seen_count;
	logic [7:0] head [0:2];
	logic [1:0] cont_left;
	logic       bad_seq;

	verdict_t   verdicts_due [$];
	stim_row_t  dir_rows [$];
	logic [7:0] text_q [$];
	logic       row_fixed = 1'b0;
	verdict_t   row_verdict = VERDICT_UNKNOWN;
	int         errors = 0;
	int         cyc = 0;
	int         sent = 0;
	logic       calm;

	assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		$display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
		errors++;
	endtask

	task automatic clear_buffer_state();
		seen_count = '0;
		head[0] = '0;
		head[1] = '0;
		head[2] = '0;
		cont_left = '0;
		bad_seq = 1'b0;
	endtask

	// Advance the predictor by one byte; a last byte yields the verdict.
	task automatic classify_byte(input logic [7:0] b, input logic last,
		output logic has_verdict, output verdict_t verdict);
		has_verdict = 1'b0;
		verdict = VERDICT_UNKNOWN;
		if (seen_count < HEAD_DEPTH)
			head[seen_count] = b;
		if (cont_left != 0) begin
			if ((b & MASK_2) != PAT_CONT)
				bad_seq = 1'b1;
			cont_left = cont_left - 2'd1;
		end else if (b[7]) begin
			// Bytes with the top bit clear are ASCII, zero included.
			if ((b & MASK_3) == PAT_LEAD2)
				cont_left = 2'd1;
			else if ((b & MASK_4) == PAT_LEAD3)
				cont_left = 2'd2;
			else if ((b & MASK_5) == PAT_LEAD4)
				cont_left = 2'd3;
			else
				bad_seq = 1'b1;
		end
		if (seen_count < COUNT_MAX)
			seen_count = seen_count + 3'd1;
		if (last) begin
			has_verdict = 1'b1;
			if (seen_count <= HEAD_DEPTH)
				verdict = VERDICT_UNKNOWN;
			else if (head[0] == BOM_FE && head[1] == BOM_FF)
				verdict = VERDICT_UTF16_BE;
			else if (head[0] == BOM_FF && head[1] == BOM_FE)
				verdict = VERDICT_UTF16_LE;
			else if (head[0] == BOM_EF && head[1] == BOM_BB && head[2] == BOM_BF)
				verdict = VERDICT_UTF8_BOM;
			else if (bad_seq || cont_left != 0)
				verdict = VERDICT_ANSI;
			else
				verdict = VERDICT_UTF8;
			clear_buffer_state();
		end
	endtask

	// Cycle counter and run limit.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Check verdict beats first, then predict from the accepted input beat.
	always @(posedge clk) begin : scoreboard
		logic     has_verdict;
		verdict_t predicted;
		verdict_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					report_mismatch("verdict with none pending", m_tdata, 8'h00);
				end else begin
					want = verdicts_due.pop_front();
					if (m_tdata[2:0] !== want)
						report_mismatch("verdict", {5'd0, m_tdata[2:0]}, {5'd0, want});
					if (m_tdata[7:3] !== 5'd0)
						report_mismatch("padding bits", {3'd0, m_tdata[7:3]}, 8'h00);
				end
			end
			if (s_tvalid && s_tready) begin
				classify_byte(s_tdata, s_tlast, has_verdict, predicted);
				if (has_verdict)
					verdicts_due.push_back(row_fixed ? row_verdict : predicted);
			end
		end
	end

	// The result side stalls at random outside the calm window.
	always @(negedge clk) begin
		m_tready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic add_row(input logic [7:0] data, input logic last, input logic fixed,
		input verdict_t verdict);
		stim_row_t row;
		row.data = data;
		row.last = last;
		row.fixed = fixed;
		row.verdict = verdict;
		dir_rows.push_back(row);
	endtask

	// Drive one byte beat from a falling edge and hold it until it is taken.
	task automatic send_byte(input logic [7:0] data, input logic last, input logic fixed,
		input verdict_t verdict);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = data;
		s_tlast = last;
		row_fixed = fixed;
		row_verdict = verdict;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	// Append one well-formed UTF-8 character of 1 to 4 bytes with random payload.
	task automatic push_char();
		int pick;
		int n;
		logic [31:0] r;
		pick = $urandom_range(0, 99);
		r = $urandom;
		if (pick < 40) begin
			text_q.push_back({1'b0, r[6:0]});
			n = 0;
		end else if (pick < 60) begin
			text_q.push_back({3'b110, r[4:0]});
			n = 1;
		end else if (pick < 80) begin
			text_q.push_back({4'b1110, r[3:0]});
			n = 2;
		end else begin
			text_q.push_back({5'b11110, r[2:0]});
			n = 3;
		end
		repeat (n) begin
			r = $urandom;
			text_q.push_back({2'b10, r[5:0]});
		end
	endtask

	// Pick a byte that is often one of the mark bytes, to hit near-marks.
	function automatic logic [7:0] mark_biased_byte();
		logic [7:0] b;
		b = 8'($urandom);
		case ($urandom_range(0, 9))
			0: b = BOM_FE;
			1: b = BOM_FF;
			2: b = BOM_EF;
			3: b = BOM_BB;
			default: begin
			end
		endcase
		return b;
	endfunction

	// Build one random buffer: mostly well-formed text, with marks, damage and noise.
	task automatic build_buffer();
		int len;
		int pick;
		int kind;
		int pos;
		text_q.delete();
		pick = $urandom_range(0, 99);
		if (pick < 8)
			len = $urandom_range(1, 3);
		else if (pick < 95)
			len = $urandom_range(4, 12);
		else
			len = $urandom_range(13, 40);
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			text_q.push_back(BOM_EF);
			text_q.push_back(BOM_BB);
			text_q.push_back(BOM_BF);
			while (text_q.size() < len)
				push_char();
		end else if (kind < 22) begin
			text_q.push_back(kind < 16 ? BOM_FE : BOM_FF);
			text_q.push_back(kind < 16 ? BOM_FF : BOM_FE);
			while (text_q.size() < len)
				text_q.push_back(8'($urandom));
		end else if (kind < 90) begin
			while (text_q.size() < len)
				push_char();
			// Damage some buffers: a random byte, or a sequence cut off at the end.
			if (kind >= 75) begin
				if ($urandom_range(0, 1) == 0) begin
					pos = $urandom_range(0, text_q.size() - 1);
					text_q[pos] = 8'($urandom);
				end else if (text_q.size() > 1) begin
					void'(text_q.pop_back());
				end
			end
		end else begin
			while (text_q.size() < len)
				text_q.push_back(mark_biased_byte());
		end
	endtask

	// Stimulus: reset, directed table, random buffers, then drain.
	initial begin
		clear_buffer_state();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Shortest buffer, a zero byte: too short to judge.
		add_row(8'h00, 1'b1, 1'b1, VERDICT_UNKNOWN);
		// Three bytes of all ones: still too short.
		add_row(8'hff, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'hff, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'hff, 1'b1, 1'b1, VERDICT_UNKNOWN);
		// Big-endian UTF-16 mark.
		add_row(BOM_FE, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(BOM_FF, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h00, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h00, 1'b1, 1'b1, VERDICT_UTF16_BE);
		// Little-endian UTF-16 mark.
		add_row(BOM_FF, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(BOM_FE, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h41, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h00, 1'b1, 1'b1, VERDICT_UTF16_LE);
		// UTF-8 mark wins over a stray continuation after it.
		add_row(BOM_EF, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(BOM_BB, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(BOM_BF, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h80, 1'b1, 1'b1, VERDICT_UTF8_BOM);
		// Clean two- and three-byte sequences with ASCII around them.
		add_row(8'hc3, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'ha9, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'he2, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h82, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'hac, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h7f, 1'b1, 1'b1, VERDICT_UTF8);
		// Bad lead byte, stray continuation, and a four-byte lead cut off at the end.
		add_row(8'hf8, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h80, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'h41, 1'b0, 1'b0, VERDICT_UNKNOWN);
		add_row(8'hf0, 1'b1, 1'b0, VERDICT_UNKNOWN);

		@(negedge clk);
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].fixed,
				dir_rows[i].verdict);

		while (sent < RANDOM_BYTES + dir_rows.size()) begin
			build_buffer();
			foreach (text_q[i])
				send_byte(text_q[i], i == text_q.size() - 1, 1'b0, VERDICT_UNKNOWN);
		end
		s_tvalid = 1'b0;
		s_tlast = 1'b0;

		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> text_encoding_detector_unit.f
hdl/ted_pkg.sv
hdl/ted_track.sv
hdl/text_encoding_detector_unit.sv
hdl/ted_checker.sv
verif/tb_text_encoding_detector_unit.sv
